@@ rtl/core/shs_pkg.sv @@
// shs_pkg: shared types, constants and the rotate function of the sha-256 stream hasher
// no dependencies
package shs_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int BLK_BYTES = 64;
	localparam int ROUNDS = 64;
	localparam int QDEPTH = 2;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [511:0] block;
		logic         fin;
	} blk_item_t;

	typedef enum logic [1:0] {
		FR_FILL,
		FR_PAD2
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_ADD,
		BK_OUT
	} back_state_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror(input word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ rtl/core/sha256_stream_hasher_core.sv @@
// sha256_stream_hasher_core: top level of the sha-256 stream hasher
// depends on shs_pkg, shs_front, shs_queue, shs_back
//
// input channel: valid/stall with data_byte, has_byte, last_byte. one byte per
// transaction; has_byte low with last_byte high ends the message without a byte.
// output channel: valid/stall carrying eight digest words, word_index 0..7,
// digest_last on the eighth.
// the front packs bytes at one per cycle while not stalled and hands each full
// or padded block to a two-entry queue; the back runs one round per cycle
// through each block (load, 64 rounds, hash add) and takes no new block until
// it is done with the last. the digest follows the last block's hash add, as
// eight words at one per cycle unless the receiver stalls.
// a stalled receiver holds the current word; blocks back up into the queue
// and then the input stalls. reset clears all control state and reloads the
// initial hash; no clearing pass is needed.
module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	import shs_pkg::*;

	blk_item_t f_item, b_item;
	logic      f_valid, f_stall, b_valid, b_stall;

	shs_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall),
		.data_byte, .has_byte, .last_byte,
		.blk_valid(f_valid), .blk_stall(f_stall), .blk(f_item)
	);

	shs_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_stall(f_stall), .in_item(f_item),
		.out_valid(b_valid), .out_stall(b_stall), .out_item(b_item)
	);

	shs_back u_back (
		.clk, .arst_n, .blk_valid(b_valid), .blk_stall(b_stall), .blk(b_item),
		.valid(out_valid), .stall(out_stall),
		.digest_word, .word_index, .digest_last
	);
endmodule

@@ rtl/core/shs_front.sv @@
// shs_front: packs bytes into blocks and builds the padded final blocks
// depends on shs_pkg
module shs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  logic [7:0]        data_byte,
	input  logic              has_byte,
	input  logic              last_byte,
	output logic              blk_valid,
	input  logic              blk_stall,
	output shs_pkg::blk_item_t blk
);
	import shs_pkg::*;

	front_state_t state_q, state_d;
	logic [511:0] block_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic         mark_q;
	logic [63:0]  len_next;
	logic [511:0] cur;
	logic [511:0] padded;
	logic         wrap;
	logic         acc;

	always_comb begin
		cur = block_q;
		if (has_byte) begin
			cur[511 - 8 * fill_q -: 8] = data_byte;
		end
	end

	assign len_next = has_byte ? len_q + 64'd8 : len_q;
	assign wrap = has_byte && (fill_q == 6'd63);

	always_comb begin
		logic [6:0] pos;
		pos = {1'b0, fill_q} + {6'd0, has_byte};
		padded = cur;
		for (int i = 0; i < BLK_BYTES; i++) begin
			if (i == pos) begin
				padded[511 - 8 * i -: 8] = PAD_MARK;
			end else if (i > pos) begin
				padded[511 - 8 * i -: 8] = 8'd0;
			end
		end
		if (pos < 7'd56) begin
			padded[63:0] = len_next;
		end
	end

	// output selection per item class
	always_comb begin
		logic [6:0] pos;
		pos = {1'b0, fill_q} + {6'd0, has_byte};
		blk_valid = 1'b0;
		blk.block = padded;
		blk.fin = 1'b0;
		state_d = state_q;
		stall = 1'b0;
		if (state_q == FR_PAD2) begin
			stall = 1'b1;
			blk_valid = 1'b1;
			blk.block = {(mark_q ? PAD_MARK : 8'd0), 440'd0, len_q};
			blk.fin = 1'b1;
			if (!blk_stall) begin
				state_d = FR_FILL;
			end
		end else if (valid) begin
			if (last_byte) begin
				blk_valid = 1'b1;
				if (pos == 7'd64) begin
					blk.block = cur;
					state_d = blk_stall ? FR_FILL : FR_PAD2;
				end else if (pos >= 7'd56) begin
					state_d = blk_stall ? FR_FILL : FR_PAD2;
				end else begin
					blk.fin = 1'b1;
				end
				stall = blk_stall;
			end else if (wrap) begin
				blk_valid = 1'b1;
				blk.block = cur;
				stall = blk_stall;
			end
		end
	end

	assign acc = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_FILL;
			fill_q <= '0;
			len_q <= '0;
			mark_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				if (last_byte) begin
					fill_q <= '0;
					len_q <= (state_d == FR_PAD2) ? len_next : 64'd0;
					mark_q <= wrap;
				end else begin
					fill_q <= fill_q + {5'd0, has_byte};
					len_q <= len_next;
				end
			end else if (state_q == FR_PAD2 && !blk_stall) begin
				len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			block_q <= cur;
		end
	end

	// while a second pad block is due, the front takes no input, offers that block as final and has its fill cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_PAD2 |-> stall)
		else $error("front accepted during pad block");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_PAD2 |-> blk_valid && blk.fin)
		else $error("pad block not final");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_PAD2 |-> fill_q == 6'd0)
		else $error("fill not cleared before pad block");
endmodule

@@ rtl/core/shs_queue.sv @@
// shs_queue: short block queue between front and back
// depends on shs_pkg
module shs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  shs_pkg::blk_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output shs_pkg::blk_item_t out_item
);
	import shs_pkg::*;

	blk_item_t  mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall = (cnt_q == 2'(QDEPTH));
	assign out_valid = (cnt_q != 2'd0);
	assign out_item = mem_q[rp_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("queue head changed while stalled");
endmodule

@@ rtl/core/shs_back.sv @@
// shs_back: 64-round compression, one round per cycle, and digest output
// depends on shs_pkg
module shs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               blk_valid,
	output logic               blk_stall,
	input  shs_pkg::blk_item_t blk,
	output logic               valid,
	input  logic               stall,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               digest_last
);
	import shs_pkg::*;

	back_state_t state_q, state_d;
	word_t      h_q [8];
	word_t      v_q [8];
	word_t      w_q [16];
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;
	word_t      wr, t1, t2, s0, s1;
	logic       take;

	assign take = (state_q == BK_IDLE) && blk_valid;
	assign blk_stall = (state_q != BK_IDLE);

	always_comb begin
		s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wr = w_q[0];
		t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + wr;
		t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (blk_valid) state_d = BK_RUN;
			BK_RUN:  if (rnd_q == 6'(ROUNDS - 1)) state_d = BK_ADD;
			BK_ADD:  state_d = fin_q ? BK_OUT : BK_IDLE;
			BK_OUT:  if (!stall && idx_q == 3'd7) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		valid = (state_q == BK_OUT);
		digest_word = h_q[idx_q];
		word_index = idx_q;
		digest_last = (idx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			h_q <= INIT_H;
		end else begin
			state_q <= state_d;
			if (take) begin
				rnd_q <= '0;
				fin_q <= blk.fin;
			end else if (state_q == BK_RUN) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == BK_ADD) begin
				for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
				idx_q <= '0;
			end
			if (state_q == BK_OUT && !stall) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) h_q <= INIT_H;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < 16; j++) w_q[j] <= blk.block[511 - 32 * j -: 32];
			v_q <= h_q;
		end else if (state_q == BK_RUN) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j + 1];
			w_q[15] <= w_q[0] + s0 + w_q[9] + s1;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_RUN && rnd_q == 6'(ROUNDS - 1) |=> state_q == BK_ADD)
		else $error("round count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(idx_q))
		else $error("digest word moved while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_OUT |-> fin_q)
		else $error("digest out of non-final block");
endmodule
